### sv/fpu_pkg.sv
// ----------------------------------------------------------------------------
// fpu_pkg
// Shared types, constants and helper functions of the factorial power unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fpu_pkg;

   // fraction bits of the log2 and exp2 working format
   localparam int LOGQ = 30;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TERM,
      ST_TERM_WAIT,
      ST_FRAC,
      ST_LOG,
      ST_LOG_WAIT,
      ST_LG_MUL,
      ST_LG_WAIT,
      ST_EXP,
      ST_EXP_WAIT,
      ST_FAC,
      ST_FAC_WAIT,
      ST_RECIP,
      ST_DIV,
      ST_DIV_END,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic         done;
      logic [127:0] prod;
   } mul_rsp_type;

   // 2^(2^-i) in Q.30 for i = 0..30
   typedef logic [LOGQ:0][31:0] exp_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bitv;
      x    = x_in;
      res  = 64'd0;
      bitv = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic exp_tab_type build_exp_tab();
      exp_tab_type t;
      logic [63:0] v;
      v    = 64'd2 << LOGQ;
      t[0] = 32'(v);
      for (int j = 1; j <= LOGQ; j++) begin
         v    = isqrt64(v << LOGQ);
         t[j] = 32'(v);
      end
      return t;
   endfunction

   // magnitude product rounded half up at bit sh, clamped, sign applied
   // returns {clamped, value}
   function automatic logic [64:0] round_clamp(input logic [127:0] prod, input int sh,
                                               input logic neg);
      logic [127:0] rnd;
      logic [127:0] mag;
      logic [63:0]  lim;
      logic [63:0]  m64;
      logic         sat;
      rnd = prod + (128'd1 << (sh - 1));
      mag = rnd >> sh;
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      sat = mag > {64'd0, lim};
      m64 = sat ? lim : mag[63:0];
      return {sat, neg ? 64'(64'd0 - m64) : m64};
   endfunction

endpackage

`default_nettype wire

### sv/fpu_if.sv
// ----------------------------------------------------------------------------
// fpu channel interfaces
// Request and response channels of the factorial power unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpu_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] conc;
   logic signed [15:0] exponent;
   logic signed [31:0] step;
   modport source (output valid, conc, exponent, step, input ready);
   modport sink (input valid, conc, exponent, step, output ready);
endinterface

interface fpu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;
   logic               zero_forced;
   logic               saturated;
   modport source (output valid, value, zero_forced, saturated, input ready);
   modport sink (input valid, value, zero_forced, saturated, output ready);
endinterface

`default_nettype wire

### sv/fpu_mul.sv
// ----------------------------------------------------------------------------
// fpu_mul
// Shared 64 x 64 unsigned multiplier built from one 32 x 32 multiplier,
// one partial product per cycle, accumulated into the 128-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module fpu_mul (
   input  wire                  clock,
   input  wire                  reset,
   input  fpu_pkg::mul_req_type req,
   output fpu_pkg::mul_rsp_type rsp
);

   logic [63:0]  a_ff, a_in;
   logic [63:0]  b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]   phase_ff, phase_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;

   logic [31:0]  a_sel;
   logic [31:0]  b_sel;
   logic [127:0] pp_sh;

   always_comb begin
      case (phase_ff)
         2'd0: begin
            a_sel = a_ff[31:0];
            b_sel = b_ff[31:0];
            pp_sh = 128'({32'd0, a_sel} * {32'd0, b_sel});
         end
         2'd1: begin
            a_sel = a_ff[31:0];
            b_sel = b_ff[63:32];
            pp_sh = 128'({32'd0, a_sel} * {32'd0, b_sel}) << 32;
         end
         2'd2: begin
            a_sel = a_ff[63:32];
            b_sel = b_ff[31:0];
            pp_sh = 128'({32'd0, a_sel} * {32'd0, b_sel}) << 32;
         end
         default: begin
            a_sel = a_ff[63:32];
            b_sel = b_ff[63:32];
            pp_sh = 128'({32'd0, a_sel} * {32'd0, b_sel}) << 64;
         end
      endcase
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (req.start) begin
         a_in     = req.a;
         b_in     = req.b;
         acc_in   = 128'd0;
         phase_in = 2'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in   = acc_ff + pp_sh;
         phase_in = phase_ff + 2'd1;
         if (phase_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      phase_ff <= phase_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

endmodule

`default_nettype wire

### sv/factorial_power_unit_core.sv
// ----------------------------------------------------------------------------
// factorial_power_unit_core
// Rising / falling factorial power of a Q16.16 base with a Q8.8 exponent,
// Q32.32 result with zero and clamp flags.
// ----------------------------------------------------------------------------
// One item at a time. All multiplies go through one shared multiplier. An
// item with integer exponent part N and fraction bits set runs N products
// for the terms, the log2 (30 squarings), exp2 (one product per set bit)
// and the final scaling; a negative exponent adds a bit-serial division.
// The result is held in an output register until transferred; the request
// side is ready again after that.
`default_nettype none

module factorial_power_unit_core #(
   parameter int CONC_FRAC_BITS   = 16,
   parameter int EXP_FRAC_BITS    = 8,
   parameter int RESULT_FRAC_BITS = 32
) (
   input  wire       clock,
   input  wire       reset,
   fpu_req_if.sink   req_ch,
   fpu_rsp_if.source rsp_ch
);

   localparam int IPW  = 17 - EXP_FRAC_BITS;
   localparam int IDXW = $clog2(2 * RESULT_FRAC_BITS + 2);
   localparam int LQ   = fpu_pkg::LOGQ;
   localparam fpu_pkg::exp_tab_type EXP_TAB = fpu_pkg::build_exp_tab();
   localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;

   fpu_pkg::state_type state_ff, state_in;

   logic signed [31:0]      conc_ff, conc_in;
   logic signed [31:0]      step_ff, step_in;
   logic                    negx_ff, negx_in;
   logic [EXP_FRAC_BITS-1:0] k_ff, k_in;
   logic [IPW-1:0]          ip_ff, ip_in;
   logic [IPW-1:0]          cnt_ff, cnt_in;
   logic signed [63:0]      term_ff, term_in;
   logic signed [63:0]      p_ff, p_in;
   logic                    sat_ff, sat_in;
   logic                    zf_ff, zf_in;
   logic                    mneg_ff, mneg_in;
   logic [30:0]             mant_ff, mant_in;
   logic [29:0]             frac_ff, frac_in;
   logic [4:0]              m_ff, m_in;
   logic [IDXW-1:0]         idx_ff, idx_in;
   logic [29:0]             g_ff, g_in;
   logic signed [8:0]       n_ff, n_in;
   logic [31:0]             r_ff, r_in;
   logic [63:0]             rem_ff, rem_in;
   logic [63:0]             q_ff, q_in;
   logic                    ov_ff, ov_in;

   fpu_pkg::mul_req_type mul_req;
   fpu_pkg::mul_rsp_type mul_rsp;

   fpu_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   // scratch values of the combinational block
   logic signed [16:0] exs;
   logic [16:0]        ae;
   logic [64:0]        rc;
   logic [4:0]         msb;
   logic signed [7:0]  e8;
   logic signed [37:0] lg;
   logic [63:0]        ym;
   logic signed [63:0] y;
   logic [31:0]        sq;
   logic signed [9:0]  s;
   logic [63:0]        fac;
   logic               fsat;
   logic [64:0]        rem_sh;
   logic [63:0]        qn;

   always_comb begin
      state_in = state_ff;
      conc_in  = conc_ff;
      step_in  = step_ff;
      negx_in  = negx_ff;
      k_in     = k_ff;
      ip_in    = ip_ff;
      cnt_in   = cnt_ff;
      term_in  = term_ff;
      p_in     = p_ff;
      sat_in   = sat_ff;
      zf_in    = zf_ff;
      mneg_in  = mneg_ff;
      mant_in  = mant_ff;
      frac_in  = frac_ff;
      m_in     = m_ff;
      idx_in   = idx_ff;
      g_in     = g_ff;
      n_in     = n_ff;
      r_in     = r_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      ov_in    = ov_ff;
      mul_req  = '0;

      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;

      exs = 17'(req_ch.exponent);
      ae  = exs[16] ? 17'(-exs) : 17'(exs);
      rc  = '0;
      msb = 5'd0;
      for (int j = 0; j < 31; j++) begin
         if (conc_ff[j]) begin
            msb = 5'(j);
         end
      end
      e8  = $signed({3'b000, m_ff}) - 8'(CONC_FRAC_BITS);
      lg  = {e8, frac_ff};
      ym  = 64'((mul_rsp.prod + (128'd1 << (EXP_FRAC_BITS - 1))) >> EXP_FRAC_BITS);
      y   = mneg_ff ? $signed(64'd0 - ym) : $signed(ym);
      sq  = 32'(mul_rsp.prod >> LQ);
      s   = 10'(n_ff) + 10'(RESULT_FRAC_BITS - LQ);
      fac  = 64'd0;
      fsat = 1'b0;
      if (s >= 0) begin
         if (s >= 63) begin
            fsat = 1'b1;
         end else if (s > 0 && (({32'd0, r_ff} >> (6'd63 - 6'(s))) != 64'd0)) begin
            fsat = 1'b1;
         end else begin
            fac = {32'd0, r_ff} << 6'(s);
         end
         if (fsat) begin
            fac = MAX64;
         end
      end else if (s > -63) begin
         fac = ({32'd0, r_ff} + (64'd1 << (6'(-s) - 6'd1))) >> 6'(-s);
      end
      rem_sh = {rem_ff, idx_ff == IDXW'(2 * RESULT_FRAC_BITS)};
      qn     = q_ff + 64'd1;

      case (state_ff)
         fpu_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               conc_in  = req_ch.conc;
               step_in  = req_ch.step;
               negx_in  = req_ch.exponent[15];
               ip_in    = ae[16:EXP_FRAC_BITS];
               k_in     = ae[EXP_FRAC_BITS-1:0];
               cnt_in   = '0;
               term_in  = 64'(req_ch.conc) + ((req_ch.step > 0) ? 64'(req_ch.step) : 64'sd0);
               p_in     = 64'sd1 <<< RESULT_FRAC_BITS;
               sat_in   = 1'b0;
               zf_in    = 1'b0;
               state_in = fpu_pkg::ST_TERM;
            end
         end
         fpu_pkg::ST_TERM: begin
            if (cnt_ff == ip_ff) begin
               state_in = fpu_pkg::ST_FRAC;
            end else begin
               mul_req.start = 1'b1;
               mul_req.a     = p_ff[63] ? 64'(64'd0 - p_ff) : p_ff;
               mul_req.b     = term_ff[63] ? 64'(64'd0 - term_ff) : term_ff;
               mneg_in       = p_ff[63] ^ term_ff[63];
               state_in      = fpu_pkg::ST_TERM_WAIT;
            end
         end
         fpu_pkg::ST_TERM_WAIT: begin
            if (mul_rsp.done) begin
               rc       = fpu_pkg::round_clamp(mul_rsp.prod, CONC_FRAC_BITS, mneg_ff);
               p_in     = rc[63:0];
               sat_in   = sat_ff | rc[64];
               term_in  = term_ff + 64'(step_ff);
               cnt_in   = cnt_ff + 1'b1;
               state_in = fpu_pkg::ST_TERM;
            end
         end
         fpu_pkg::ST_FRAC: begin
            if (k_ff == '0) begin
               state_in = fpu_pkg::ST_RECIP;
            end else if (conc_ff <= 0) begin
               p_in     = 64'sd0;
               zf_in    = 1'b1;
               state_in = fpu_pkg::ST_RECIP;
            end else begin
               m_in     = msb;
               mant_in  = 31'({32'd0, conc_ff} << (5'd30 - msb));
               frac_in  = '0;
               idx_in   = '0;
               state_in = fpu_pkg::ST_LOG;
            end
         end
         fpu_pkg::ST_LOG: begin
            mul_req.start = 1'b1;
            mul_req.a     = {33'd0, mant_ff};
            mul_req.b     = {33'd0, mant_ff};
            state_in      = fpu_pkg::ST_LOG_WAIT;
         end
         fpu_pkg::ST_LOG_WAIT: begin
            if (mul_rsp.done) begin
               frac_in = {frac_ff[28:0], sq[31]};
               mant_in = sq[31] ? sq[31:1] : sq[30:0];
               idx_in  = idx_ff + 1'b1;
               state_in = (idx_ff == IDXW'(LQ - 1)) ? fpu_pkg::ST_LG_MUL : fpu_pkg::ST_LOG;
            end
         end
         fpu_pkg::ST_LG_MUL: begin
            mul_req.start = 1'b1;
            mul_req.a     = 64'(lg[37] ? 38'(-lg) : 38'(lg));
            mul_req.b     = 64'(k_ff);
            mneg_in       = lg[37];
            state_in      = fpu_pkg::ST_LG_WAIT;
         end
         fpu_pkg::ST_LG_WAIT: begin
            if (mul_rsp.done) begin
               n_in     = 9'(y >>> LQ);
               g_in     = y[29:0];
               r_in     = 32'd1 << LQ;
               idx_in   = IDXW'(1);
               state_in = fpu_pkg::ST_EXP;
            end
         end
         fpu_pkg::ST_EXP: begin
            if (idx_ff == IDXW'(LQ + 1)) begin
               state_in = fpu_pkg::ST_FAC;
            end else if (g_ff[5'(5'd30 - idx_ff[4:0])]) begin
               mul_req.start = 1'b1;
               mul_req.a     = {32'd0, r_ff};
               mul_req.b     = {32'd0, EXP_TAB[idx_ff[4:0]]};
               state_in      = fpu_pkg::ST_EXP_WAIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         fpu_pkg::ST_EXP_WAIT: begin
            if (mul_rsp.done) begin
               r_in     = 32'((mul_rsp.prod + (128'd1 << (LQ - 1))) >> LQ);
               idx_in   = idx_ff + 1'b1;
               state_in = fpu_pkg::ST_EXP;
            end
         end
         fpu_pkg::ST_FAC: begin
            sat_in        = sat_ff | fsat;
            mul_req.start = 1'b1;
            mul_req.a     = p_ff[63] ? 64'(64'd0 - p_ff) : p_ff;
            mul_req.b     = fac;
            mneg_in       = p_ff[63];
            state_in      = fpu_pkg::ST_FAC_WAIT;
         end
         fpu_pkg::ST_FAC_WAIT: begin
            if (mul_rsp.done) begin
               rc       = fpu_pkg::round_clamp(mul_rsp.prod, RESULT_FRAC_BITS, mneg_ff);
               p_in     = rc[63:0];
               sat_in   = sat_ff | rc[64];
               state_in = fpu_pkg::ST_RECIP;
            end
         end
         fpu_pkg::ST_RECIP: begin
            if (!negx_ff) begin
               state_in = fpu_pkg::ST_OUT;
            end else if (p_ff <= 0) begin
               p_in     = 64'sd0;
               zf_in    = 1'b1;
               state_in = fpu_pkg::ST_OUT;
            end else begin
               rem_in   = '0;
               q_in     = '0;
               ov_in    = 1'b0;
               idx_in   = IDXW'(2 * RESULT_FRAC_BITS);
               state_in = fpu_pkg::ST_DIV;
            end
         end
         fpu_pkg::ST_DIV: begin
            // restoring division, one quotient bit per cycle
            ov_in = ov_ff | q_ff[62];
            if (rem_sh >= {1'b0, p_ff}) begin
               rem_in = 64'(rem_sh - {1'b0, p_ff});
               q_in   = {q_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh[63:0];
               q_in   = {q_ff[62:0], 1'b0};
            end
            if (idx_ff == '0) begin
               state_in = fpu_pkg::ST_DIV_END;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         fpu_pkg::ST_DIV_END: begin
            if (!ov_ff && rem_ff >= 64'(p_ff) - rem_ff) begin
               q_in = qn;
            end
            if (ov_ff || q_in > MAX64) begin
               sat_in = 1'b1;
               p_in   = $signed(MAX64);
            end else begin
               p_in = $signed(q_in);
            end
            state_in = fpu_pkg::ST_OUT;
         end
         fpu_pkg::ST_OUT: begin
            rsp_ch.valid = 1'b1;
            if (rsp_ch.ready) begin
               state_in = fpu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fpu_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      conc_ff <= conc_in;
      step_ff <= step_in;
      negx_ff <= negx_in;
      k_ff    <= k_in;
      ip_ff   <= ip_in;
      cnt_ff  <= cnt_in;
      term_ff <= term_in;
      p_ff    <= p_in;
      sat_ff  <= sat_in;
      zf_ff   <= zf_in;
      mneg_ff <= mneg_in;
      mant_ff <= mant_in;
      frac_ff <= frac_in;
      m_ff    <= m_in;
      idx_ff  <= idx_in;
      g_ff    <= g_in;
      n_ff    <= n_in;
      r_ff    <= r_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      ov_ff   <= ov_in;
   end

   assign rsp_ch.value       = p_ff;
   assign rsp_ch.zero_forced = zf_ff;
   assign rsp_ch.saturated   = sat_ff & ~zf_ff;

endmodule

`default_nettype wire

### sv/fpu_checker.sv
// ----------------------------------------------------------------------------
// fpu_checker
// Port-level checks of the factorial power unit, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module fpu_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [63:0] rsp_value,
   input wire        rsp_zero_forced,
   input wire        rsp_saturated
);

   // one item in flight: ready drops once a request is taken
   a_busy_after_req : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an item is in flight");

   a_one_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("result shown twice");

   a_idle_no_rsp : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("ready for a request with a result pending");

   a_forced_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_forced) |-> (!rsp_saturated && rsp_value == 64'd0))
      else $error("forced zero with non-zero value or clamp flag");

endmodule

bind factorial_power_unit_core fpu_checker u_fpu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_value       (rsp_ch.value),
   .rsp_zero_forced (rsp_ch.zero_forced),
   .rsp_saturated   (rsp_ch.saturated)
);

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the factorial power unit core. A short stimulus
// table with its extremes, flagged results and rising / falling products is
// followed by random requests. Requests without a table result go through
// a bit-exact model of the unit's arithmetic. Each response is compared to
// the oldest expected result while both channels idle at random by phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CFB = 16;
   localparam int EFB = 8;
   localparam int RFB = 32;
   localparam int LQ  = 30;
   localparam int N_RANDOM = 830;
   localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
   localparam logic [63:0] MAX64   = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] MIN64   = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [63:0] value;
      logic        zero_forced;
      logic        saturated;
   } power_result_type;

   typedef struct packed {
      logic [31:0]      conc;
      logic [15:0]      exponent;
      logic [31:0]      step;
      logic             typed;
      power_result_type res;
   } stim_row_type;

   logic clock;
   logic reset;

   fpu_req_if req_ch ();
   fpu_rsp_if rsp_ch ();

   factorial_power_unit_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   power_result_type expected_q[$];
   int               n_mismatch;
   int               idle_pct;
   int               stall_pct;
   logic [63:0]      exp2_tab[LQ + 1];

   // ----- arithmetic model -----

   function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
      logic [63:0] r;
      r = 64'd0;
      for (int b = 31; b >= 0; b--) begin
         if (({64'd0, r | (64'd1 << b)} * {64'd0, r | (64'd1 << b)}) <= {64'd0, x})
            r = r | (64'd1 << b);
      end
      return r;
   endfunction

   // round(a*b / 2^sh) on the magnitude, half up, clamped to the signed range
   function automatic logic signed [63:0] scaled_mul(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input int sh, inout logic sat);
      logic         neg;
      logic [63:0]  ua;
      logic [63:0]  ub;
      logic [127:0] pr;
      logic [127:0] lim;
      neg = (a < 0) != (b < 0);
      ua  = a < 0 ? 64'd0 - a : a;
      ub  = b < 0 ? 64'd0 - b : b;
      pr  = ({64'd0, ua} * {64'd0, ub} + (128'd1 << (sh - 1))) >> sh;
      lim = neg ? {64'd0, MIN64} : {64'd0, MAX64};
      if (pr > lim) begin
         sat = 1'b1;
         pr  = lim;
      end
      return neg ? 64'd0 - pr[63:0] : pr[63:0];
   endfunction

   // conc^(k / 2^EFB) in Q32.32 via log2 and exp2
   function automatic logic signed [63:0] root_factor(input logic [63:0] c,
                                                      input logic [63:0] k,
                                                      inout logic sat);
      int                 msb;
      int                 s;
      logic [63:0]        mant;
      logic [63:0]        lfrac;
      logic [63:0]        r;
      logic signed [63:0] lg;
      logic signed [63:0] pr;
      logic signed [63:0] y;
      logic signed [63:0] n;
      logic [63:0]        g;
      msb   = 0;
      lfrac = 64'd0;
      for (int j = 0; j < 63; j++) if (c[j]) msb = j;
      mant = c << (LQ - msb);
      for (int j = 0; j < LQ; j++) begin
         mant  = (mant * mant) >> LQ;
         lfrac = lfrac << 1;
         if (mant >= (64'd2 << LQ)) begin
            mant     = mant >> 1;
            lfrac[0] = 1'b1;
         end
      end
      lg = (64'(msb) - CFB) * (64'sd1 <<< LQ) + $signed(lfrac);
      pr = lg * $signed(k);
      if (pr >= 0) y = (pr + (64'sd1 <<< (EFB - 1))) >>> EFB;
      else y = -((-pr + (64'sd1 <<< (EFB - 1))) >>> EFB);
      n = y >>> LQ;
      g = y & ((64'd1 << LQ) - 1);
      r = 64'd1 << LQ;
      for (int j = 1; j <= LQ; j++) begin
         if (g[LQ - j]) r = (r * exp2_tab[j] + (64'd1 << (LQ - 1))) >> LQ;
      end
      s = int'(n) + RFB - LQ;
      if (s >= 0) begin
         if (s >= 63 || (s > 0 && (r >> (63 - s)) != 0)) begin
            sat = 1'b1;
            return MAX64;
         end
         return r << s;
      end else if (s <= -63) begin
         return 64'd0;
      end
      return (r + (64'd1 << (-s - 1))) >> (-s);
   endfunction

   // round(2^(2*RFB) / d), half up, clamped
   function automatic logic signed [63:0] reciprocal(input logic [63:0] d, inout logic sat);
      logic [127:0] q;
      logic [127:0] rm;
      q  = (128'd1 << (2 * RFB)) / {64'd0, d};
      rm = (128'd1 << (2 * RFB)) % {64'd0, d};
      if (q < {64'd0, MIN64} && rm >= {64'd0, d} - rm) q = q + 1;
      if (q > {64'd0, MAX64}) begin
         sat = 1'b1;
         return MAX64;
      end
      return q[63:0];
   endfunction

   function automatic power_result_type factorial_power(input logic [31:0] conc_in,
                                                        input logic [15:0] exp_in,
                                                        input logic [31:0] step_in);
      logic signed [63:0] conc;
      logic signed [63:0] ex;
      logic signed [63:0] stp;
      logic signed [63:0] ae;
      logic signed [63:0] term;
      logic signed [63:0] p;
      logic signed [63:0] fac;
      logic [63:0]        k;
      logic               sat;
      logic               zf;
      power_result_type   res;
      conc = {{32{conc_in[31]}}, conc_in};
      ex   = {{48{exp_in[15]}}, exp_in};
      stp  = {{32{step_in[31]}}, step_in};
      ae   = ex < 0 ? -ex : ex;
      k    = ae & ((64'd1 << EFB) - 1);
      term = conc + (stp > 0 ? stp : 64'sd0);
      p    = ONE_Q32;
      sat  = 1'b0;
      zf   = 1'b0;
      for (int j = 0; j < int'(ae >>> EFB); j++) begin
         p    = scaled_mul(p, term, CFB, sat);
         term = term + stp;
      end
      if (k > 0) begin
         if (conc <= 0) begin
            p  = 64'sd0;
            zf = 1'b1;
         end else begin
            fac = root_factor(conc, k, sat);
            p   = scaled_mul(p, fac, RFB, sat);
         end
      end
      if (ex < 0) begin
         if (p <= 0) begin
            p  = 64'sd0;
            zf = 1'b1;
         end else begin
            p = reciprocal(p, sat);
         end
      end
      res.value       = p;
      res.zero_forced = zf;
      res.saturated   = zf ? 1'b0 : sat;
      return res;
   endfunction

   // ----- directed table -----

   localparam int N_ROWS = 20;
   stim_row_type stim_table[N_ROWS] = '{
      '{32'h0001_0000, 16'h0000, 32'h0000_0000, 1'b1, '{ONE_Q32, 1'b0, 1'b0}},
      '{32'h8000_0000, 16'h0000, 32'h7fff_ffff, 1'b1, '{ONE_Q32, 1'b0, 1'b0}},
      '{32'h0001_0000, 16'h0100, 32'h0000_0000, 1'b1, '{ONE_Q32, 1'b0, 1'b0}},
      '{32'h0000_0000, 16'h0080, 32'h0000_0000, 1'b1, '{64'd0, 1'b1, 1'b0}},
      '{32'hffff_0000, 16'h0180, 32'h0000_0000, 1'b1, '{64'd0, 1'b1, 1'b0}},
      '{32'hffff_0000, 16'hff00, 32'h0000_0000, 1'b1, '{64'd0, 1'b1, 1'b0}},
      '{32'h0000_0000, 16'hff00, 32'h0000_0000, 1'b1, '{64'd0, 1'b1, 1'b0}},
      '{32'h0002_0000, 16'hff00, 32'h0000_0000, 1'b1, '{64'h8000_0000, 1'b0, 1'b0}},
      '{32'h7fff_ffff, 16'h0400, 32'h0000_0000, 1'b1, '{MAX64, 1'b0, 1'b1}},
      '{32'h8000_0000, 16'h0300, 32'h0000_0000, 1'b1, '{MIN64, 1'b0, 1'b1}},
      '{32'h0005_0000, 16'h0400, 32'hffff_0000, 1'b0, '0},
      '{32'h0003_0000, 16'h0300, 32'h0001_0000, 1'b0, '0},
      '{32'h0002_0000, 16'h0080, 32'h0000_0000, 1'b0, '0},
      '{32'h7fff_ffff, 16'h7fff, 32'h0000_0000, 1'b0, '0},
      '{32'h0001_0000, 16'h8000, 32'h0000_0001, 1'b0, '0},
      '{32'h0000_0001, 16'hff80, 32'h0000_0000, 1'b0, '0},
      '{32'h0000_0001, 16'h0001, 32'h0000_0000, 1'b0, '0},
      '{32'h0000_8000, 16'hc000, 32'h0000_0000, 1'b0, '0},
      '{32'h0001_0000, 16'h0101, 32'h8000_0000, 1'b0, '0},
      '{32'h0003_0000, 16'hfe80, 32'h7fff_ffff, 1'b0, '0}
   };

   // ----- clock, reset, limit -----

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("Mismatches found");
      $finish;
   end

   // ----- request side -----

   task automatic send_request(input logic [31:0] c, input logic [15:0] e,
                               input logic [31:0] s, input logic typed,
                               input power_result_type res);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.conc     <= c;
      req_ch.exponent <= e;
      req_ch.step     <= s;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_q.push_back(typed ? res : factorial_power(c, e, s));
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_conc();
      case ($urandom_range(9))
         0, 1:    return $urandom;
         2:       return 32'(-$signed({1'b0, 31'($urandom_range(32'h0008_0000))}));
         3:       return $urandom_range(32'h0000_0100);
         default: return $urandom_range(32'h0004_0000, 32'h0000_4000);
      endcase
   endfunction

   function automatic logic [31:0] rand_step();
      case ($urandom_range(7))
         0, 1, 2: return 32'd0;
         3:       return $urandom;
         4:       return 32'(-$signed({1'b0, 31'($urandom_range(32'h0002_0000))}));
         default: return $urandom_range(32'h0002_0000);
      endcase
   endfunction

   function automatic logic [15:0] rand_exponent();
      logic [15:0] e;
      if ($urandom_range(19) == 0) return 16'($urandom);
      e = {5'd0, 3'($urandom_range(6)), 8'($urandom)};
      if ($urandom_range(3) == 0) e[7:0] = 8'd0;
      return $urandom_range(1) ? 16'(-e) : e;
   endfunction

   initial begin
      power_result_type none;
      none       = '0;
      n_mismatch = 0;
      idle_pct   = 0;
      stall_pct  = 0;
      exp2_tab[0] = 64'd2 << LQ;
      for (int j = 1; j <= LQ; j++) exp2_tab[j] = sqrt_floor(exp2_tab[j - 1] << LQ);
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.conc     = '0;
      req_ch.exponent = '0;
      req_ch.step     = '0;
      rsp_ch.ready    = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (stim_table[r])
         send_request(stim_table[r].conc, stim_table[r].exponent, stim_table[r].step,
                      stim_table[r].typed, stim_table[r].res);
      for (int j = 0; j < N_RANDOM; j++) begin
         case (j * 4 / N_RANDOM)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 70; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 70; end
            default: begin idle_pct = 10; stall_pct = 10; end
         endcase
         send_request(rand_conc(), rand_exponent(), rand_step(), 1'b0, none);
      end
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (n_mismatch == 0 && expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // ----- response side -----

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      power_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected transfer value=%h", rsp_ch.value);
         end else begin
            want = expected_q.pop_front();
            if (rsp_ch.value !== want.value || rsp_ch.zero_forced !== want.zero_forced ||
                rsp_ch.saturated !== want.saturated) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("mismatch: value %h/%h zero_forced %b/%b saturated %b/%b",
                           want.value, rsp_ch.value, want.zero_forced,
                           rsp_ch.zero_forced, want.saturated, rsp_ch.saturated);
            end
         end
      end
   end

endmodule

`default_nettype wire
